[src/wpm_pkg.sv]
// Shared types and constants for the wildcard pattern matcher.
package wpm_pkg;

	localparam int unsigned PAT_REGS    = 4;
	localparam int unsigned PAT_BITS    = PAT_REGS * 64;
	localparam int unsigned LEN_W       = 6;
	localparam int unsigned IDX_W       = 3;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
	localparam logic [IDX_W-1:0] REG_PATTERN_0_7    = 3'd1;
	localparam logic [IDX_W-1:0] REG_PATTERN_8_15   = 3'd2;
	localparam logic [IDX_W-1:0] REG_PATTERN_16_23  = 3'd3;
	localparam logic [IDX_W-1:0] REG_PATTERN_24_31  = 3'd4;

	// Request modes
	localparam logic [1:0] MODE_CONTINUE = 2'd0;
	localparam logic [1:0] MODE_LAST     = 2'd1;
	localparam logic [1:0] MODE_EMPTY    = 2'd2;

	// Wildcard characters
	localparam logic [7:0] CHAR_STAR = 8'h2A;
	localparam logic [7:0] CHAR_ANY  = 8'h3F;

	typedef struct packed {
		logic       load;
		logic       clear;
		logic       started;
		logic [7:0] text_byte;
	} wpm_ctrl_t;

endpackage

[src/wpm_cell.sv]
// One pattern position of the match row: holds its bit and updates it per text byte.
module wpm_cell import wpm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  wpm_ctrl_t  ctrl,
	input  logic [7:0] pat_byte,
	input  logic       active,
	input  logic       left_base,
	input  logic       left_init,
	input  logic       left_new,
	output logic       base,
	output logic       init,
	output logic       row_new
);

	logic row_q;
	logic is_star;
	logic hit;

	assign is_star = (pat_byte == CHAR_STAR);
	assign hit     = (pat_byte == CHAR_ANY) || (pat_byte == ctrl.text_byte);

	// leading stars extend the empty-prefix row
	assign init    = active && is_star && left_init;
	assign base    = ctrl.started ? row_q : init;
	assign row_new = active && (is_star ? (left_new || base) : (hit && left_base));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 1'b0;
		end else if (ctrl.clear) begin
			row_q <= 1'b0;
		end else if (ctrl.load) begin
			row_q <= row_new;
		end
	end

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clear |=> !row_q)
		else $error("cell bit not cleared at end of text");

endmodule

[src/wpm_out_buf.sv]
// Two-entry output register with skid stage for match results.
module wpm_out_buf (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic push_bit,
	output logic full,
	output logic out_valid,
	input  logic out_ready,
	output logic matched
);

	logic out_valid_q;
	logic out_q;
	logic skid_valid_q;
	logic skid_q;
	logic pop;

	assign pop       = out_valid_q && out_ready;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign matched   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= push;
			end else begin
				out_valid_q <= push;
			end
		end else if (!out_valid_q) begin
			out_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= push_bit;
			end else begin
				out_q <= push_bit;
			end
		end else if (!out_valid_q) begin
			out_q <= push_bit;
		end else if (push) begin
			skid_q <= push_bit;
		end
	end

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with empty output register");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !pop) |-> !push)
		else $error("result pushed into full buffer");

endmodule

[src/wildcard_pattern_matcher.sv]
// Top level of the wildcard pattern matcher: config, cell row and result buffer.
//
// Channel  Direction  Handshake           Payload
// in       request    in_valid/in_ready   mode, text_byte
// out      result     out_valid/out_ready matched
// cfg      write      cfg_write           cfg_index, cfg_data
//
// One request is taken per cycle while in_ready is high; its result is pushed
// into the result buffer. The row update is a single pass through the cell
// chain, with star runs rippling left to right inside the cycle.
// Reset clears the row, the text-started flag, the pattern registers and the
// result buffer. in_ready drops only when both result entries are occupied.
module wildcard_pattern_matcher import wpm_pkg::*; #(
	parameter int unsigned PATTERN_MAX = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [63:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          mode,
	input  logic [7:0]          text_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                matched
);

	localparam int unsigned LW = $clog2(PATTERN_MAX + 1);

	logic [LEN_W-1:0]    pattern_length_q;
	logic [PAT_BITS-1:0] pattern_q;
	logic                text_started_q;

	logic                accept;
	logic                buf_full;
	logic [LW-1:0]       len_eff;
	wpm_ctrl_t           ctrl;

	// Chain vectors: index 0 is the fixed empty-pattern position
	logic [PATTERN_MAX:0] base_v;
	logic [PATTERN_MAX:0] init_v;
	logic [PATTERN_MAX:0] new_v;

	logic                 res_push;
	logic                 res_bit;

	assign in_ready = !buf_full;
	assign accept   = in_valid && in_ready;

	// Lengths beyond the cell count clamp to the last cell
	assign len_eff = (pattern_length_q > LEN_W'(PATTERN_MAX)) ? LW'(PATTERN_MAX)
	                                                         : pattern_length_q[LW-1:0];

	assign ctrl.load      = accept && (mode == MODE_CONTINUE);
	assign ctrl.clear     = accept && ((mode == MODE_LAST) || (mode == MODE_EMPTY));
	assign ctrl.started   = text_started_q;
	assign ctrl.text_byte = text_byte;

	// Position 0: matches only before the first byte
	assign init_v[0] = 1'b1;
	assign base_v[0] = !text_started_q;
	assign new_v[0]  = 1'b0;

	for (genvar j = 1; j <= PATTERN_MAX; j++) begin : g_cell
		wpm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.pat_byte  (pattern_q[(j-1)*8 +: 8]),
			.active    (LW'(j) <= len_eff),
			.left_base (base_v[j-1]),
			.left_init (init_v[j-1]),
			.left_new  (new_v[j-1]),
			.base      (base_v[j]),
			.init      (init_v[j]),
			.row_new   (new_v[j])
		);
	end

	// Last byte reads the updated row; empty text reads the empty-prefix row
	assign res_push = ctrl.clear;
	assign res_bit  = (mode == MODE_EMPTY) ? init_v[len_eff] : new_v[len_eff];

	wpm_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_bit  (res_bit),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.matched   (matched)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_started_q <= 1'b0;
		end else if (ctrl.clear) begin
			text_started_q <= 1'b0;
		end else if (ctrl.load) begin
			text_started_q <= 1'b1;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= '0;
			pattern_q        <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LEN_W-1:0];
				REG_PATTERN_0_7:    pattern_q[63:0]    <= cfg_data;
				REG_PATTERN_8_15:   pattern_q[127:64]  <= cfg_data;
				REG_PATTERN_16_23:  pattern_q[191:128] <= cfg_data;
				REG_PATTERN_24_31:  pattern_q[255:192] <= cfg_data;
				default: ;
			endcase
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clear |=> !text_started_q)
		else $error("text still marked started after its result");

	a_byte_starts: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |=> text_started_q)
		else $error("text not marked started after a byte");

endmodule

[tb/wpm_checker.sv]
// Checker for the wildcard pattern matcher: predicts each answer and compares it.
module wpm_checker import wpm_pkg::*; #(
	parameter int unsigned PATTERN_MAX = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [63:0]      cfg_data,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [1:0]       mode,
	input  logic [7:0]       text_byte,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic             matched,
	output int               pending,
	output int               failures
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [LEN_W-1:0]    len_reg;
	logic [PAT_BITS-1:0] pat_reg;
	logic [32:0]         row;
	bit                  started;
	logic                answers_q[$];
	logic                want;
	logic [32:0]         fresh;
	int                  span;
	int                  waiting = 0;
	int                  errs = 0;

	assign pending  = waiting;
	assign failures = errs;

	function automatic int live_len();
		int n;
		n = int'(len_reg);
		if (n > int'(PATTERN_MAX))
			n = PATTERN_MAX;
		return n;
	endfunction

	function automatic logic [7:0] pchar(int k);
		return pat_reg[k*8 +: 8];
	endfunction

	// empty prefix matches position 0 and any run of leading stars
	function automatic logic [32:0] start_row(int n);
		logic [32:0] r;
		r = 33'd1;
		for (int j = 1; j <= n; j++) begin
			if (pchar(j - 1) == CHAR_STAR && r[j - 1])
				r[j] = 1'b1;
			else
				break;
		end
		return r;
	endfunction

	// one text byte: stars take left (same row) or upper (previous row) neighbour
	function automatic logic [32:0] next_row(logic [32:0] prev, int n, logic [7:0] c);
		logic [32:0] r;
		logic [7:0]  p;
		r = '0;
		for (int j = 1; j <= n; j++) begin
			p = pchar(j - 1);
			if (p == CHAR_STAR)
				r[j] = r[j - 1] | prev[j];
			else if (p == CHAR_ANY || p == c)
				r[j] = prev[j - 1];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_reg = '0;
			pat_reg = '0;
			row     = '0;
			started = 1'b0;
			answers_q.delete();
			waiting = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (answers_q.size() == 0) begin
					$error("matched: no result expected, actual %0b", matched);
					errs = errs + 1;
				end else begin
					want = answers_q.pop_front();
					if (matched !== want) begin
						$error("matched: expected %0b, actual %0b", want, matched);
						errs = errs + 1;
					end
				end
			end
			if (in_valid && in_ready) begin
				span = live_len();
				case (mode)
					MODE_EMPTY: begin
						fresh = start_row(span);
						answers_q.push_back(fresh[span]);
						row     = '0;
						started = 1'b0;
					end
					MODE_CONTINUE, MODE_LAST: begin
						if (!started) begin
							row     = start_row(span);
							started = 1'b1;
						end
						row = next_row(row, span, text_byte);
						if (mode == MODE_LAST) begin
							answers_q.push_back(row[span]);
							row     = '0;
							started = 1'b0;
						end
					end
					default: ;
				endcase
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_PATTERN_LENGTH: len_reg = cfg_data[LEN_W-1:0];
					REG_PATTERN_0_7:    pat_reg[63:0]    = cfg_data;
					REG_PATTERN_8_15:   pat_reg[127:64]  = cfg_data;
					REG_PATTERN_16_23:  pat_reg[191:128] = cfg_data;
					REG_PATTERN_24_31:  pat_reg[255:192] = cfg_data;
					default: ;
				endcase
			end
			waiting = answers_q.size();
		end
	end

endmodule

[tb/tb.sv]
// Testbench top for the wildcard pattern matcher: stimulus, stalls and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wpm_pkg::*;

	localparam int RANDOM_ITEMS = 1300;
	localparam int LIMIT_CYCLES = 500000;
	// the fourth mode value is undefined; the block must swallow it
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [7:0] LETTER_A = 8'h61;
	localparam logic [7:0] LETTER_B = 8'h62;
	localparam logic [7:0] LETTER_C = 8'h63;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_write = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [63:0]      cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [1:0]       mode = MODE_CONTINUE;
	logic [7:0]       text_byte = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic             matched;
	int               pending;
	int               failures;

	int         cycles = 0;
	int         items_sent = 0;
	bit         calm_in = 1'b0;
	bit         calm_out = 1'b0;
	// pattern as generated for the current phase, used to load it and to build texts
	logic [7:0] pat_chars[32];
	int         pat_n;
	logic [7:0] text_q[$];

	wildcard_pattern_matcher #(.PATTERN_MAX(32)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.text_byte (text_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.matched   (matched)
	);

	wpm_checker #(.PATTERN_MAX(32)) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.text_byte (text_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.matched   (matched),
		.pending   (pending),
		.failures  (failures)
	);

	always #5ns clk = ~clk;

	// hard stop, well above the slowest legal run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// Random per-item wait; now and then a side flips into a calm
	// stretch with no waits at all, so back-to-back traffic is seen too.
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 49) == 0)
			calm = ~calm;
		return calm ? 0 : $urandom_range(0, 16);
	endfunction

	// Text bytes: mostly a tiny alphabet so patterns hit, plus wildcards as
	// plain text and full-range bytes to toggle every bit.
	function automatic logic [7:0] filler();
		int r;
		r = $urandom_range(0, 7);
		if (r < 2)
			return 8'($urandom_range(0, 255));
		if (r == 2)
			return CHAR_STAR;
		if (r == 3)
			return CHAR_ANY;
		return 8'(LETTER_A + $urandom_range(0, 2));
	endfunction

	function automatic logic [7:0] pick_pat_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return CHAR_STAR;
		if (r == 2)
			return CHAR_ANY;
		if (r == 3)
			return 8'($urandom_range(0, 255));
		return 8'(LETTER_A + $urandom_range(0, 2));
	endfunction

	// One request on the input channel; called and returns on a falling edge.
	// valid is only lowered when there is a real gap, never lowered and raised
	// in the same step.
	task automatic send(input logic [1:0] m, input logic [7:0] b);
		int w;
		w = draw_wait(calm_in);
		if (w > 0) begin
			in_valid <= 1'b0;
			repeat (w) @(negedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= m;
		text_byte <= b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (m != MODE_UNUSED)
			items_sent++;
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [63:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	task automatic load_pattern(input logic [63:0] len_word, input logic [255:0] bits);
		write_reg(REG_PATTERN_LENGTH, len_word);
		write_reg(REG_PATTERN_0_7, bits[63:0]);
		write_reg(REG_PATTERN_8_15, bits[127:64]);
		write_reg(REG_PATTERN_16_23, bits[191:128]);
		write_reg(REG_PATTERN_24_31, bits[255:192]);
		cfg_write <= 1'b0;
	endtask

	// Quiesce before touching registers: all answers in, and a trailing continue
	// byte (which gives no answer) absorbed as well.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic choose_pattern();
		int            kind;
		logic [255:0]  bits;
		logic [63:0]   len_word;
		kind = $urandom_range(0, 9);
		if (kind == 0)
			pat_n = 0;
		else if (kind == 1)
			pat_n = 32;
		else
			pat_n = $urandom_range(1, 10);
		// bytes past the length get junk; they must be ignored
		for (int k = 0; k < 32; k++) begin
			pat_chars[k] = (k < pat_n) ? pick_pat_char() : 8'($urandom_range(0, 255));
			bits[k*8 +: 8] = pat_chars[k];
		end
		len_word = {$urandom, $urandom};
		len_word[LEN_W-1:0] = LEN_W'(pat_n);
		// full-length pattern, sometimes with an oversized length value
		if (pat_n == 32 && $urandom_range(0, 1) == 1)
			len_word[LEN_W-1:0] = LEN_W'($urandom_range(33, 63));
		load_pattern(len_word, bits);
	endtask

	// Build a text that follows the pattern, then maybe spoil it; a tenth of
	// texts are plain noise.
	task automatic make_text();
		int pos;
		text_q.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(0, 6)) text_q.push_back(8'($urandom_range(0, 255)));
			return;
		end
		for (int k = 0; k < pat_n; k++) begin
			if (pat_chars[k] == CHAR_STAR)
				repeat ($urandom_range(0, 3)) text_q.push_back(filler());
			else if (pat_chars[k] == CHAR_ANY)
				text_q.push_back(filler());
			else
				text_q.push_back(pat_chars[k]);
		end
		if ($urandom_range(0, 2) == 0) begin
			case ($urandom_range(0, 2))
				0: if (text_q.size() > 0) begin
					pos = $urandom_range(0, text_q.size() - 1);
					text_q[pos] = filler();
				end
				1: if (text_q.size() > 0)
					text_q.delete($urandom_range(0, text_q.size() - 1));
				default: text_q.insert($urandom_range(0, text_q.size()), filler());
			endcase
		end
	endtask

	// Stream the text; undefined-mode requests are sprinkled in, and now and
	// then an empty-text request cuts the text short.
	task automatic send_text();
		if (text_q.size() == 0) begin
			send(MODE_EMPTY, 8'($urandom));
			return;
		end
		for (int i = 0; i < text_q.size(); i++) begin
			if ($urandom_range(0, 24) == 0)
				send(MODE_UNUSED, 8'($urandom));
			if (i > 0 && $urandom_range(0, 39) == 0) begin
				send(MODE_EMPTY, 8'($urandom));
				return;
			end
			send((i == text_q.size() - 1) ? MODE_LAST : MODE_CONTINUE, text_q[i]);
		end
	endtask

	// Result side: stall before each answer, then hold ready until one is taken.
	initial begin
		int w;
		@(negedge clk);
		forever begin
			w = draw_wait(calm_out);
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin
		int phase_end;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty pattern straight after reset: only the empty text matches.
		send(MODE_EMPTY, 8'hFF);
		send(MODE_LAST, 8'h00);

		// "a*?b" with junk bytes beyond the length.
		wait_idle();
		load_pattern(64'd4, {192'h0, 8'hA5, 8'hC3, 8'h0F, 8'h11,
			LETTER_B, CHAR_ANY, CHAR_STAR, LETTER_A} | {32'hFFFF_FFFF, 224'h0});
		send(MODE_CONTINUE, LETTER_A);
		send(MODE_CONTINUE, LETTER_C);
		send(MODE_LAST, LETTER_B);
		// wildcard bytes in the text are ordinary characters
		send(MODE_CONTINUE, LETTER_A);
		send(MODE_CONTINUE, CHAR_STAR);
		send(MODE_CONTINUE, CHAR_STAR);
		send(MODE_LAST, LETTER_B);
		send(MODE_CONTINUE, LETTER_A);
		send(MODE_LAST, LETTER_B);

		// Literal pattern "a": a '*' or '?' in the text is no wildcard.
		wait_idle();
		load_pattern(64'd1, {248'h0, LETTER_A});
		send(MODE_LAST, CHAR_STAR);
		send(MODE_LAST, CHAR_ANY);

		// Oversized length (63) clamps to 32: 31 stars then 0xFF. Byte extremes,
		// an undefined-mode request mid-text, then an empty-text request that
		// abandons a partial text.
		wait_idle();
		load_pattern({58'h2AA_AAAA_AAAA_AAAA, 6'd63}, {8'hFF, {31{CHAR_STAR}}});
		send(MODE_CONTINUE, 8'h00);
		send(MODE_UNUSED, 8'hFF);
		send(MODE_LAST, 8'hFF);
		send(MODE_LAST, 8'hFF);
		send(MODE_CONTINUE, 8'h00);
		send(MODE_EMPTY, 8'h00);

		// Register rewrite while a text is open: "ab" becomes "cb" after 'a'.
		wait_idle();
		load_pattern(64'd2, {240'h0, LETTER_B, LETTER_A});
		send(MODE_CONTINUE, LETTER_A);
		wait_idle();
		write_reg(REG_PATTERN_0_7, {48'h0, LETTER_B, LETTER_C});
		cfg_write <= 1'b0;
		send(MODE_LAST, LETTER_B);

		// Random phases, each under a fresh pattern.
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			wait_idle();
			choose_pattern();
			phase_end = items_sent + $urandom_range(40, 90);
			while (items_sent < phase_end && items_sent < RANDOM_ITEMS) begin
				make_text();
				send_text();
			end
		end

		// drain, then allow the last answers to settle
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (failures == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
